// ----- src/hct_pkg.sv -----
// Shared types and constants for the hybrid clock tick reserve block.
`timescale 1ns / 1ps
package hct_pkg;

    localparam int HCT_NUM_COMPONENTS = 4;

    localparam int COMP_W   = 2;
    localparam int TICK_W   = 31;
    localparam int SECS_W   = 32;
    localparam int INC_W    = 32;
    localparam int TIME_W   = SECS_W + INC_W;
    localparam int MAXINC_W = 31;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 64;

    localparam logic [MAXINC_W-1:0] MAX_INC_RESET = 31'h7FFF_FFFF;

    localparam logic KIND_RESERVE = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SYNC,
        S_ADV
    } t_state;

    typedef struct packed {
        logic load;
        logic sync;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ----- src/hct_ctrl.sv -----
// Controller state machine sequencing load, sync and advance of one item.
`timescale 1ns / 1ps
module hct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  hct_pkg::t_dp_sts  i_sts,
    output hct_pkg::t_dp_cmd  o_cmd
);
    import hct_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_s_tvalid) begin
                    n_state = S_SYNC;
                end
            end
            S_SYNC: begin
                n_state = S_ADV;
            end
            S_ADV: begin
                if (i_sts.out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.sync   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_SYNC: begin
                o_cmd.sync = 1'b1;
            end
            S_ADV: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/hct_dp.sv -----
// Datapath: clock vector store, sync and tick arithmetic, result register.
`timescale 1ns / 1ps
module hct_dp #(
    parameter int NUM_COMPONENTS = hct_pkg::HCT_NUM_COMPONENTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [hct_pkg::MAXINC_W-1:0]    i_cfg_wr_data,
    input  logic [hct_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [hct_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                            o_m_tuser,
    input  hct_pkg::t_dp_cmd                i_cmd,
    output hct_pkg::t_dp_sts                o_sts
);
    import hct_pkg::*;

    localparam int IDX_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
    localparam int EXT_W = IDX_W + COMP_W;

    logic [TIME_W-1:0]   r_store [NUM_COMPONENTS];
    logic [MAXINC_W-1:0] r_max_inc;

    logic                r_kind;
    logic [IDX_W-1:0]    r_idx;
    logic                r_comp_ok;
    logic [TICK_W-1:0]   r_ticks;
    logic [SECS_W-1:0]   r_wall;
    logic [TIME_W-1:0]   r_target;
    logic [TIME_W-1:0]   r_t;
    logic [TIME_W-1:0]   r_base;
    logic                r_jump;
    logic [TICK_W-1:0]   r_step;

    logic                r_out_valid;
    logic [TIME_W-1:0]   r_out_time;
    logic                r_out_jump;

    logic [COMP_W-1:0]   in_comp;
    logic [EXT_W-1:0]    comp_ext;
    logic [IDX_W-1:0]    in_idx;
    logic                in_ok;

    logic [SECS_W-1:0]   t_secs;
    logic [INC_W-1:0]    t_inc;
    logic [INC_W:0]      inc_sum;
    logic [TIME_W-1:0]   n_base;
    logic                n_jump;
    logic [TIME_W-1:0]   first_time;
    logic [TIME_W-1:0]   store_time;

    assign in_comp  = i_s_tdata[COMP_W-1:0];
    assign comp_ext = {{IDX_W{1'b0}}, in_comp};
    assign in_idx   = comp_ext[IDX_W-1:0];
    assign in_ok    = comp_ext < EXT_W'(NUM_COMPONENTS);

    assign t_secs  = r_t[TIME_W-1:INC_W];
    assign t_inc   = r_t[INC_W-1:0];
    assign inc_sum = {1'b0, t_inc} + {2'b00, r_ticks};

    always_comb begin
        n_base = r_t;
        n_jump = 1'b0;
        if (r_kind == KIND_RESERVE) begin
            if (t_secs < r_wall) begin
                n_base = {r_wall, {INC_W{1'b0}}};
                n_jump = 1'b1;
            end else if (inc_sum > {2'b00, r_max_inc}) begin
                n_base = {t_secs + SECS_W'(1), {INC_W{1'b0}}};
                n_jump = 1'b1;
            end
        end else begin
            if (r_target > r_t) begin
                n_base = r_target;
                n_jump = 1'b1;
            end
        end
        if (!r_comp_ok) begin
            n_jump = 1'b0;
        end
    end

    assign first_time = r_base + TIME_W'(1);
    assign store_time = r_base + {{(TIME_W-TICK_W){1'b0}}, r_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_inc <= MAX_INC_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_inc <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_s_tuser;
            r_idx     <= in_idx;
            r_comp_ok <= in_ok;
            r_ticks   <= i_s_tdata[COMP_W+TICK_W-1:COMP_W];
            r_wall    <= i_s_tdata[COMP_W+TICK_W+SECS_W-1:COMP_W+TICK_W];
            r_target  <= {i_s_tdata[COMP_W+TICK_W+2*SECS_W-1:COMP_W+TICK_W+SECS_W],
                          i_s_tdata[COMP_W+TICK_W+2*SECS_W+INC_W-1:COMP_W+TICK_W+2*SECS_W]};
            r_t       <= in_ok ? r_store[in_idx] : '0;
        end
        if (i_cmd.sync) begin
            r_base <= n_base;
            r_jump <= n_jump;
            r_step <= (r_ticks == '0) ? TICK_W'(1) : r_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COMPONENTS; k++) begin
                r_store[k] <= '0;
            end
        end else if (i_cmd.commit && r_comp_ok) begin
            if (r_kind == KIND_RESERVE) begin
                r_store[r_idx] <= store_time;
            end else begin
                r_store[r_idx] <= r_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_jump <= r_jump;
            if (!r_comp_ok) begin
                r_out_time <= '0;
            end else if (r_kind == KIND_RESERVE) begin
                r_out_time <= first_time;
            end else begin
                r_out_time <= r_base;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = {r_out_time[INC_W-1:0], r_out_time[TIME_W-1:INC_W]};
    assign o_m_tuser      = r_out_jump;

endmodule

// ----- src/hybrid_clock_tick_reserve.sv -----
// Top level: hybrid logical clock vector with tick reservation and advance-to.
// Steps: the load step captures the input, the sync step registers the base time
// and the advance step writes the result register, waiting while the output is
// stalled. A new item is accepted only after the last result has been registered.
// Reset: synchronous, active low; clears every component time to zero and sets
// max_increment to 2^31-1.
`timescale 1ns / 1ps
module hybrid_clock_tick_reserve #(
    parameter int NUM_COMPONENTS = hct_pkg::HCT_NUM_COMPONENTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [hct_pkg::MAXINC_W-1:0]    i_cfg_wr_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // component, tick_count, wall_secs, new_time_secs, new_time_inc, zero pad
    input  logic [hct_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // kind
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // time_secs, time_inc
    output logic [hct_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // jumped
    output logic                            o_m_tuser
);
    import hct_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    hct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hct_dp #(
        .NUM_COMPONENTS (NUM_COMPONENTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after a transfer");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared while idle");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_s_tready && !o_m_tvalid))
        else $error("block not idle after reset");
`endif

endmodule
